FILE: rtl/eac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eac_pkg
// Shared types, character codes and the byte classifier of the address checker.
// ----------------------------------------------------------------------------
package eac_pkg;

    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [7:0] CH_AT         = 8'h40;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [1:0] MIN_TAIL      = 2'd2;

    // byte classes as the back end sees them
    typedef enum logic [2:0] {
        CC_AT,
        CC_DOT,
        CC_ALNUM,
        CC_DASH,
        CC_LOCAL_SYM,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        logic        end_marker;
        char_class_t cls;
    } eac_item_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        if (c == CH_AT)
            r = CC_AT;
        else if (c == CH_DOT)
            r = CC_DOT;
        else if (c == CH_DASH)
            r = CC_DASH;
        else if (c == CH_UNDERSCORE || c == CH_PLUS)
            r = CC_LOCAL_SYM;
        else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A))
            r = CC_ALNUM;
        else
            r = CC_OTHER;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/eac_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eac_front
// Input stage: takes stream transfers and registers each byte as a class code.
// ----------------------------------------------------------------------------
module eac_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_char,
    input  wire logic              in_end,
    output logic                   push,
    output eac_pkg::eac_item_t     push_item,
    input  wire logic              push_ready
);
    import eac_pkg::*;

    logic      valid_reg, valid_next;
    eac_item_t item_reg,  item_next;

    // stage empties into the queue whenever the queue has room
    assign in_ready  = !valid_reg || push_ready;
    assign push      = valid_reg && push_ready;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                item_next.end_marker = in_end;
                item_next.cls        = classify(in_char);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule
`default_nettype wire

FILE: rtl/eac_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eac_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module eac_fifo #(
    parameter int unsigned DEPTH = eac_pkg::FIFO_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire eac_pkg::eac_item_t push_item,
    output logic                   push_ready,
    output logic                   pop_valid,
    output eac_pkg::eac_item_t     pop_item,
    input  wire logic              pop
);
    import eac_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    eac_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ on empty queue");

endmodule
`default_nettype wire

FILE: rtl/eac_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eac_back
// Rule tracker: updates the address flags per byte and registers the verdict.
// ----------------------------------------------------------------------------
module eac_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    input  wire eac_pkg::eac_item_t pop_item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_ok
);
    import eac_pkg::*;

    typedef struct packed {
        logic       at_seen;
        logic       rule_broken;
        logic       local_nonempty;
        logic [1:0] local_dot_count;
        logic       local_ends_in_dot;
        logic       domain_nonempty;
        logic       domain_dot_seen;
        logic [1:0] chars_after_last_dot;
    } addr_state_t;

    addr_state_t st_reg, st_next;
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg, ok_next;
    logic        verdict;
    logic        is_end;

    assign is_end    = pop_item.end_marker;
    // bytes never wait on the output; an end marker needs the output register
    assign pop       = pop_valid && (!is_end || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_ok    = ok_reg;

    assign verdict = st_reg.at_seen && !st_reg.rule_broken && st_reg.local_nonempty &&
                     st_reg.domain_nonempty && st_reg.domain_dot_seen &&
                     (st_reg.chars_after_last_dot >= MIN_TAIL);

    always_comb
    begin
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ok_next        = ok_reg;
        if (pop)
        begin
            if (is_end)
            begin
                out_valid_next = 1'b1;
                ok_next        = verdict;
                st_next        = '0;
            end
            else if (pop_item.cls == CC_AT)
            begin
                if (st_reg.at_seen)
                    st_next.rule_broken = 1'b1;
                else
                begin
                    if (!st_reg.local_nonempty)
                        st_next.rule_broken = 1'b1;
                    // first local dot was also the last local byte
                    if (st_reg.local_dot_count == 2'd1 && st_reg.local_ends_in_dot)
                        st_next.rule_broken = 1'b1;
                    st_next.at_seen = 1'b1;
                end
            end
            else if (!st_reg.at_seen)
            begin
                if (pop_item.cls == CC_OTHER)
                    st_next.rule_broken = 1'b1;
                if (pop_item.cls == CC_DOT)
                begin
                    if (!st_reg.local_nonempty)
                        st_next.rule_broken = 1'b1;
                    if (st_reg.local_dot_count != 2'd2)
                        st_next.local_dot_count = st_reg.local_dot_count + 2'd1;
                    st_next.local_ends_in_dot = 1'b1;
                end
                else
                    st_next.local_ends_in_dot = 1'b0;
                st_next.local_nonempty = 1'b1;
            end
            else
            begin
                if (pop_item.cls == CC_OTHER || pop_item.cls == CC_LOCAL_SYM)
                    st_next.rule_broken = 1'b1;
                if (pop_item.cls == CC_DOT)
                begin
                    if (st_reg.domain_nonempty)
                        st_next.domain_dot_seen = 1'b1;
                    st_next.chars_after_last_dot = 2'd0;
                end
                else if (st_reg.chars_after_last_dot != 2'd2)
                    st_next.chars_after_last_dot = st_reg.chars_after_last_dot + 2'd1;
                st_next.domain_nonempty = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
    end

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_end) |=> (st_reg == '0 && out_valid_reg))
        else $error("state not cleared after end marker");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_end) |-> (!out_valid_reg || out_ready))
        else $error("verdict overwritten before transfer");

    a_ok_needs_at: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && is_end && !st_reg.at_seen) |=> !ok_reg)
        else $error("valid verdict without at sign");

    a_dot_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.local_dot_count != 2'd3)
        else $error("local dot count past saturation");

endmodule
`default_nettype wire

FILE: rtl/email_address_checker.sv
`default_nettype none
// Email address checker. Feed the address one byte per transfer on the s_axis
// side and close it with a transfer that has tlast set (its byte is ignored);
// each such end transfer yields one m_axis transfer whose bit 0 is 1 when the
// whole address passes: exactly one '@', nonempty local part and domain, the
// local part's first dot neither first nor last, a domain dot after its first
// byte, at least two bytes after the domain's last dot, and only alphanumerics
// and . _ - + before the '@', alphanumerics and . - after it. All state clears
// after each end transfer. One byte is taken every clock cycle while the
// queue has room; the rule tracker updates its flags once per item, and
// the verdict passes through the input register, the queue and the output
// register before it is presented. A queue of FIFO_DEPTH items lets the
// input keep streaming while a verdict waits on the output.
// ----------------------------------------------------------------------------
// email_address_checker
// Top level: input classifier, item queue and rule tracker on stream ports.
// ----------------------------------------------------------------------------
module email_address_checker #(
    parameter int unsigned FIFO_DEPTH = eac_pkg::FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] character
    input  wire logic       s_axis_tlast,   // end_marker
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] address_ok, [7:1] zero
);
    import eac_pkg::*;

    logic      push, push_ready;
    eac_item_t push_item;
    logic      pop, pop_valid;
    eac_item_t pop_item;
    logic      ok;

    eac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    eac_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    eac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_ok    (ok)
    );

    assign m_axis_tdata = {7'd0, ok};

endmodule
`default_nettype wire
